@@ design/ghbd_pkg.sv @@
`default_nettype none
package ghbd_pkg;

    localparam int unsigned YearW  = 14;
    localparam int unsigned MonthW = 4;
    localparam int unsigned DayW   = 5;
    localparam int unsigned HourW  = 5;
    localparam int unsigned DiffW  = 27;
    localparam int unsigned DaysW  = 23;
    localparam int unsigned HoursW = 28;
    localparam int unsigned CumW   = 9;
    localparam int unsigned Q100W  = 8;

    localparam int unsigned Recip100  = 5243;
    localparam int unsigned Recip100Sh = 19;
    localparam logic [MonthW-1:0] MonthJan = 4'd1;
    localparam logic [MonthW-1:0] MonthFeb = 4'd2;
    localparam logic [MonthW-1:0] MonthDec = 4'd12;

    typedef struct packed {
        logic              wrap;
        logic [HoursW-1:0] hours;
    } t_hour_key;

    function automatic logic [CumW-1:0] month_cum(input logic [MonthW-1:0] m);
        logic [CumW-1:0] c;
        unique case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

@@ design/gregorian_hours_between_dates.sv @@
// throughput: one request per cycle, fully pipelined, no stalls
// pipeline: month table and year/100 multiply, leap rule, day sum, hour count, compare
// reset: synchronous active-low i_rst_n clears all valid bits; o_busy is high during reset
// the receiver cannot stall; each result is shown for exactly one cycle
`default_nettype none
module gregorian_hours_between_dates (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    output logic                             o_busy,
    input  wire logic [ghbd_pkg::YearW-1:0]  i_start_year,
    input  wire logic [ghbd_pkg::MonthW-1:0] i_start_month,
    input  wire logic [ghbd_pkg::DayW-1:0]   i_start_day,
    input  wire logic [ghbd_pkg::HourW-1:0]  i_start_hour,
    input  wire logic [ghbd_pkg::YearW-1:0]  i_end_year,
    input  wire logic [ghbd_pkg::MonthW-1:0] i_end_month,
    input  wire logic [ghbd_pkg::DayW-1:0]   i_end_day,
    input  wire logic [ghbd_pkg::HourW-1:0]  i_end_hour,
    output logic                             o_valid,
    output logic [ghbd_pkg::DiffW-1:0]       o_hours_between,
    output logic                             o_start_after_end
);
    logic                accept;
    logic                va;
    logic                vb;
    ghbd_pkg::t_hour_key key_a;
    ghbd_pkg::t_hour_key key_b;

    assign o_busy = !i_rst_n;
    assign accept = i_start && !o_busy;

    ghbd_hour_count u_cnt_start (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_year  (i_start_year),
        .i_month (i_start_month),
        .i_day   (i_start_day),
        .i_hour  (i_start_hour),
        .o_valid (va),
        .o_key   (key_a)
    );

    ghbd_hour_count u_cnt_end (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_year  (i_end_year),
        .i_month (i_end_month),
        .i_day   (i_end_day),
        .i_hour  (i_end_hour),
        .o_valid (vb),
        .o_key   (key_b)
    );

    ghbd_compare u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (va && vb),
        .i_key_a (key_a),
        .i_key_b (key_b),
        .o_valid (o_valid),
        .o_diff  (o_hours_between),
        .o_after (o_start_after_end)
    );
endmodule
`default_nettype wire

@@ design/ghbd_hour_count.sv @@
`default_nettype none
module ghbd_hour_count (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [ghbd_pkg::YearW-1:0]  i_year,
    input  wire logic [ghbd_pkg::MonthW-1:0] i_month,
    input  wire logic [ghbd_pkg::DayW-1:0]   i_day,
    input  wire logic [ghbd_pkg::HourW-1:0]  i_hour,
    output logic                             o_valid,
    output ghbd_pkg::t_hour_key              o_key
);
    // stage 1: clamp month, reciprocal multiply for year / 100
    logic [ghbd_pkg::MonthW-1:0] n_m1;
    logic                        r_v1;
    logic [26:0]                 r_prod1;
    logic [ghbd_pkg::YearW-1:0]  r_y1;
    logic [ghbd_pkg::CumW-1:0]   r_cum1;
    logic                        r_febp1;
    logic [ghbd_pkg::DayW-1:0]   r_d1;
    logic [ghbd_pkg::HourW-1:0]  r_h1;

    always_comb begin
        priority if (i_month < ghbd_pkg::MonthJan) begin
            n_m1 = ghbd_pkg::MonthJan;
        end else if (i_month > ghbd_pkg::MonthDec) begin
            n_m1 = ghbd_pkg::MonthDec;
        end else begin
            n_m1 = i_month;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_prod1 <= 27'(i_year) * 27'(ghbd_pkg::Recip100);
        r_y1    <= i_year;
        r_cum1  <= ghbd_pkg::month_cum(n_m1);
        r_febp1 <= (n_m1 > ghbd_pkg::MonthFeb);
        r_d1    <= i_day;
        r_h1    <= i_hour;
    end

    // stage 2: leap rule and century corrections
    logic [ghbd_pkg::Q100W-1:0] n_q100;
    logic                       n_z100;
    logic                       n_leap;
    logic                       r_v2;
    logic [ghbd_pkg::DaysW-1:0] r_y365;
    logic [12:0]                r_c4;
    logic [ghbd_pkg::Q100W-1:0] r_c100;
    logic [5:0]                 r_c400;
    logic [ghbd_pkg::CumW-1:0]  r_mday2;
    logic [ghbd_pkg::DayW-1:0]  r_d2;
    logic [ghbd_pkg::HourW-1:0] r_h2;

    always_comb begin
        n_q100 = r_prod1[ghbd_pkg::Recip100Sh +: ghbd_pkg::Q100W];
        n_z100 = ((15'(n_q100) * 15'd100) == 15'(r_y1));
        n_leap = (r_y1[1:0] == 2'b00) && (!n_z100 || (n_q100[1:0] == 2'b00));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_y365  <= 23'(r_y1) * 23'd365;
        r_c4    <= 13'((15'(r_y1) + 15'd3) >> 2);
        r_c100  <= n_q100 + 8'(!n_z100);
        r_c400  <= 6'(n_q100 >> 2) + 6'(!(n_z100 && (n_q100[1:0] == 2'b00)));
        r_mday2 <= r_cum1 + 9'(r_febp1 && n_leap);
        r_d2    <= r_d1;
        r_h2    <= r_h1;
    end

    // stage 3: day number
    logic                       r_v3;
    logic [ghbd_pkg::DaysW-1:0] r_days3;
    logic [ghbd_pkg::HourW-1:0] r_h3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_days3 <= r_y365 + 23'(r_c4) - 23'(r_c100) + 23'(r_c400)
                 + 23'(r_mday2) + 23'(r_d2);
        r_h3    <= r_h2;
    end

    // stage 4: hour count, values below one day sort above all others
    logic [ghbd_pkg::HoursW-1:0] n_hours;
    logic                        r_v4;
    ghbd_pkg::t_hour_key         r_key4;

    always_comb begin
        n_hours = (28'(r_days3) << 4) + (28'(r_days3) << 3) + 28'(r_h3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_key4.hours <= n_hours;
        r_key4.wrap  <= (n_hours < 28'd24);
    end

    assign o_valid = r_v4;
    assign o_key   = r_key4;
endmodule
`default_nettype wire

@@ design/ghbd_compare.sv @@
`default_nettype none
module ghbd_compare (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  ghbd_pkg::t_hour_key             i_key_a,
    input  ghbd_pkg::t_hour_key             i_key_b,
    output logic                            o_valid,
    output logic [ghbd_pkg::DiffW-1:0]      o_diff,
    output logic                            o_after
);
    logic                         n_less;
    logic                         n_more;
    logic [ghbd_pkg::HoursW-1:0]  n_sub;
    logic [ghbd_pkg::DiffW-1:0]   n_diff;
    logic                         r_valid;
    logic [ghbd_pkg::DiffW-1:0]   r_diff;
    logic                         r_after;

    always_comb begin
        n_less = i_key_a < i_key_b;
        n_more = i_key_a > i_key_b;
        n_sub  = i_key_b.hours - i_key_a.hours;
        priority if (!n_less) begin
            n_diff = '0;
        end else if ((i_key_a.wrap != i_key_b.wrap) || n_sub[ghbd_pkg::HoursW-1]) begin
            n_diff = '1;
        end else begin
            n_diff = n_sub[ghbd_pkg::DiffW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_diff  <= n_diff;
        r_after <= n_more;
    end

    assign o_valid = r_valid;
    assign o_diff  = r_diff;
    assign o_after = r_after;
endmodule
`default_nettype wire

@@ design/ghbd_checker.sv @@
`default_nettype none
module ghbd_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_start,
    input wire logic                       o_busy,
    input wire logic                       o_valid,
    input wire logic [ghbd_pkg::DiffW-1:0] o_hours_between,
    input wire logic                       o_start_after_end
);
    // every accepted request gives a result strobe, and no strobe comes without one
    a_latency_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##5 o_valid)
        else $error("result missing five cycles after request");

    a_latency_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |-> ##5 !o_valid)
        else $error("result without matching request");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_start_after_end) |-> (o_hours_between == '0))
        else $error("nonzero hours with start after end");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");
endmodule

bind gregorian_hours_between_dates ghbd_checker u_ghbd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_start           (i_start),
    .o_busy            (o_busy),
    .o_valid           (o_valid),
    .o_hours_between   (o_hours_between),
    .o_start_after_end (o_start_after_end)
);
`default_nettype wire

@@ verif/gregorian_hours_between_dates_checker.sv @@
`timescale 1ns / 100ps
module gregorian_hours_between_dates_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic                        i_busy,
    input  wire logic [ghbd_pkg::YearW-1:0]  i_start_year,
    input  wire logic [ghbd_pkg::MonthW-1:0] i_start_month,
    input  wire logic [ghbd_pkg::DayW-1:0]   i_start_day,
    input  wire logic [ghbd_pkg::HourW-1:0]  i_start_hour,
    input  wire logic [ghbd_pkg::YearW-1:0]  i_end_year,
    input  wire logic [ghbd_pkg::MonthW-1:0] i_end_month,
    input  wire logic [ghbd_pkg::DayW-1:0]   i_end_day,
    input  wire logic [ghbd_pkg::HourW-1:0]  i_end_hour,
    input  wire logic                        i_valid,
    input  wire logic [ghbd_pkg::DiffW-1:0]  i_hours_between,
    input  wire logic                        i_start_after_end,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked,
    output int                               o_later_seen,
    output int                               o_saturated_seen
);

    localparam bit [63:0] HoursSat = (64'd1 << ghbd_pkg::DiffW) - 64'd1;

    typedef struct {
        bit [ghbd_pkg::DiffW-1:0] hours;
        bit                       later;
        string                    dates;
    } t_gap;

    t_gap pending_gaps[$];

    function automatic bit is_leap(input bit [63:0] y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic bit [63:0] month_days(input bit [63:0] m);
        case (m)
            64'd2:                      return 64'd28;
            64'd4, 64'd6, 64'd9, 64'd11: return 64'd30;
            default:                    return 64'd31;
        endcase
    endfunction

    // hour count since year zero, wrapping like 64-bit unsigned arithmetic
    function automatic bit [63:0] linear_hours(
        input bit [ghbd_pkg::YearW-1:0]  yr,
        input bit [ghbd_pkg::MonthW-1:0] mon,
        input bit [ghbd_pkg::DayW-1:0]   dy,
        input bit [ghbd_pkg::HourW-1:0]  hr
    );
        bit [63:0] y;
        bit [63:0] m;
        bit [63:0] days;
        y = 64'(yr);
        m = 64'(mon);
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        days = 64'd365 * y + (y + 64'd3) / 64'd4 - (y + 64'd99) / 64'd100
             + (y + 64'd399) / 64'd400;
        for (bit [63:0] i = 1; i < m; i++) begin
            days += month_days(i);
            if (i == 2 && is_leap(y)) days += 1;
        end
        days += 64'(dy);
        return days * 64'd24 + 64'(hr) - 64'd24;
    endfunction

    function automatic t_gap predict_gap();
        t_gap g;
        bit [63:0] a;
        bit [63:0] b;
        bit [63:0] diff;
        a = linear_hours(i_start_year, i_start_month, i_start_day, i_start_hour);
        b = linear_hours(i_end_year, i_end_month, i_end_day, i_end_hour);
        g.hours = '0;
        g.later = 1'b0;
        if (a < b) begin
            diff = b - a;
            if (diff > HoursSat) diff = HoursSat;
            g.hours = diff[ghbd_pkg::DiffW-1:0];
        end else if (a > b) begin
            g.later = 1'b1;
        end
        g.dates = $sformatf("%0d-%0d-%0d %0dh -> %0d-%0d-%0d %0dh",
            i_start_year, i_start_month, i_start_day, i_start_hour,
            i_end_year, i_end_month, i_end_day, i_end_hour);
        return g;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count     = 0;
        o_pending        = 0;
        o_checked        = 0;
        o_later_seen     = 0;
        o_saturated_seen = 0;
    end

    always @(posedge i_clk) begin
        t_gap want;
        if (i_rst_n) begin
            if (i_valid) begin
                if (pending_gaps.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d with no request pending",
                        i_hours_between, i_start_after_end));
                end else begin
                    want = pending_gaps.pop_front();
                    o_checked++;
                    if (want.later) o_later_seen++;
                    if (want.hours == HoursSat[ghbd_pkg::DiffW-1:0]) o_saturated_seen++;
                    if (i_hours_between !== want.hours)
                        report_mismatch($sformatf("%s: hours_between %0d, expected %0d",
                            want.dates, i_hours_between, want.hours));
                    if (i_start_after_end !== want.later)
                        report_mismatch($sformatf("%s: start_after_end %0b, expected %0b",
                            want.dates, i_start_after_end, want.later));
                end
            end
            if (i_start && !i_busy) pending_gaps.push_back(predict_gap());
        end
        o_pending = pending_gaps.size();
    end

endmodule

@@ verif/gregorian_hours_between_dates_tb.sv @@
`timescale 1ns / 100ps
module gregorian_hours_between_dates_tb;

    localparam int RandomItems = 1000;
    localparam int CycleLimit  = 200000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_start;
    logic                        o_busy;
    logic [ghbd_pkg::YearW-1:0]  i_start_year;
    logic [ghbd_pkg::MonthW-1:0] i_start_month;
    logic [ghbd_pkg::DayW-1:0]   i_start_day;
    logic [ghbd_pkg::HourW-1:0]  i_start_hour;
    logic [ghbd_pkg::YearW-1:0]  i_end_year;
    logic [ghbd_pkg::MonthW-1:0] i_end_month;
    logic [ghbd_pkg::DayW-1:0]   i_end_day;
    logic [ghbd_pkg::HourW-1:0]  i_end_hour;
    logic                        o_valid;
    logic [ghbd_pkg::DiffW-1:0]  o_hours_between;
    logic                        o_start_after_end;

    int fail_count;
    int pending;
    int checked;
    int later_seen;
    int saturated_seen;
    int cycle_count;

    gregorian_hours_between_dates dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_start_year      (i_start_year),
        .i_start_month     (i_start_month),
        .i_start_day       (i_start_day),
        .i_start_hour      (i_start_hour),
        .i_end_year        (i_end_year),
        .i_end_month       (i_end_month),
        .i_end_day         (i_end_day),
        .i_end_hour        (i_end_hour),
        .o_valid           (o_valid),
        .o_hours_between   (o_hours_between),
        .o_start_after_end (o_start_after_end)
    );

    gregorian_hours_between_dates_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .i_busy            (o_busy),
        .i_start_year      (i_start_year),
        .i_start_month     (i_start_month),
        .i_start_day       (i_start_day),
        .i_start_hour      (i_start_hour),
        .i_end_year        (i_end_year),
        .i_end_month       (i_end_month),
        .i_end_day         (i_end_day),
        .i_end_hour        (i_end_hour),
        .i_valid           (o_valid),
        .i_hours_between   (o_hours_between),
        .i_start_after_end (o_start_after_end),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_later_seen      (later_seen),
        .o_saturated_seen  (saturated_seen)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_dates(
        input int sy, input int sm, input int sd, input int sh,
        input int ey, input int em, input int ed, input int eh
    );
        i_start       <= 1'b1;
        i_start_year  <= 14'(sy);
        i_start_month <= 4'(sm);
        i_start_day   <= 5'(sd);
        i_start_hour  <= 5'(sh);
        i_end_year    <= 14'(ey);
        i_end_month   <= 4'(em);
        i_end_day     <= 5'(ed);
        i_end_hour    <= 5'(eh);
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic idle_cycles(input int n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic int month_length(input int y, input int m);
        bit leap;
        leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        case (m)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    function automatic void pick_date(
        input int ylo, input int yhi,
        output logic [13:0] y, output logic [3:0] m, output logic [4:0] d, output logic [4:0] h
    );
        y = 14'($urandom_range(yhi, ylo));
        m = 4'($urandom_range(12, 1));
        d = 5'($urandom_range(month_length(int'(y), int'(m)), 1));
        h = 5'($urandom_range(23, 0));
    endfunction

    initial begin
        logic [13:0] sy, ey;
        logic [3:0]  sm, em;
        logic [4:0]  sd, ed, sh, eh;
        int          ny;
        bit          quiet;

        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_start_year  <= '0;
        i_start_month <= '0;
        i_start_day   <= '0;
        i_start_hour  <= '0;
        i_end_year    <= '0;
        i_end_month   <= '0;
        i_end_day     <= '0;
        i_end_hour    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // equal, one hour back, full valid span both ways, one hour forward
        send_dates(2024, 2, 29, 12, 2024, 2, 29, 12);
        send_dates(2024, 3, 1, 0, 2024, 2, 29, 23);
        send_dates(1, 1, 1, 0, 9999, 12, 31, 23);
        send_dates(9999, 12, 31, 23, 1, 1, 1, 0);
        send_dates(1, 1, 1, 0, 1, 1, 1, 1);
        // year zero, day zero before the epoch, all-ones fields, saturation
        send_dates(0, 0, 0, 0, 1, 1, 1, 0);
        send_dates(16383, 15, 31, 31, 0, 0, 0, 0);
        send_dates(0, 0, 0, 0, 16383, 15, 31, 31);
        send_dates(0, 1, 1, 0, 16383, 12, 31, 23);
        send_dates(0, 2, 29, 0, 0, 3, 1, 0);
        send_dates(9999, 12, 31, 23, 10000, 1, 1, 0);
        // leap rule across february
        send_dates(2000, 2, 28, 23, 2000, 3, 1, 0);
        send_dates(1900, 2, 28, 23, 1900, 3, 1, 0);
        send_dates(2004, 2, 29, 0, 2005, 2, 28, 0);
        // month clamping
        send_dates(2020, 0, 5, 3, 2020, 1, 5, 3);
        send_dates(2020, 13, 1, 0, 2020, 15, 1, 0);
        send_dates(2020, 14, 1, 0, 2020, 12, 1, 1);
        // day and hour running past their ranges
        send_dates(2021, 3, 0, 0, 2021, 2, 28, 0);
        send_dates(2021, 2, 30, 5, 2021, 3, 2, 6);
        send_dates(2021, 4, 31, 0, 2021, 5, 1, 0);
        send_dates(2022, 6, 30, 31, 2022, 7, 1, 7);
        send_dates(2022, 6, 30, 24, 2022, 7, 1, 0);
        idle_cycles(3);

        for (int n = 0; n < RandomItems; n++) begin
            int r;
            r = $urandom_range(99, 0);
            if (r < 55) begin
                pick_date(1, 9999, sy, sm, sd, sh);
                case ($urandom_range(9, 0))
                    0: begin
                        ey = sy; em = sm; ed = sd; eh = sh;
                    end
                    1: begin
                        ey = sy; em = sm; ed = sd; eh = 5'($urandom_range(23, 0));
                    end
                    default: begin
                        ny = int'(sy) + $urandom_range(2, 0) - 1;
                        if (ny < 1) ny = 1;
                        if (ny > 9999) ny = 9999;
                        pick_date(ny, ny, ey, em, ed, eh);
                    end
                endcase
                if ($urandom_range(1, 0)) begin
                    send_dates(ey, em, ed, eh, sy, sm, sd, sh);
                end else begin
                    send_dates(sy, sm, sd, sh, ey, em, ed, eh);
                end
            end else if (r < 75) begin
                pick_date(1, 9999, sy, sm, sd, sh);
                pick_date(1, 9999, ey, em, ed, eh);
                send_dates(sy, sm, sd, sh, ey, em, ed, eh);
            end else if (r < 90) begin
                pick_date(0, 16383, sy, sm, sd, sh);
                pick_date(0, 16383, ey, em, ed, eh);
                send_dates(sy, sm, sd, sh, ey, em, ed, eh);
            end else begin
                send_dates(int'(14'($urandom)), int'(4'($urandom)),
                           int'(5'($urandom)), int'(5'($urandom)),
                           int'(14'($urandom)), int'(4'($urandom)),
                           int'(5'($urandom)), int'(5'($urandom)));
            end

            // drain the pipeline once mid-run
            if (n == 700) begin
                i_start <= 1'b0;
                do @(negedge i_clk); while (pending != 0);
                @(posedge i_clk);
            end

            quiet = (n >= 300 && n < 550);
            if (!quiet && $urandom_range(99, 0) < 9) idle_cycles($urandom_range(4, 1));
        end

        i_start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);

        $display("checked %0d date pairs: %0d with start after end, %0d saturated",
            checked, later_seen, saturated_seen);
        $display("directed cases covered leap rules, clamped months, day and hour overrun");
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ gregorian_hours_between_dates.f @@
design/ghbd_pkg.sv
design/ghbd_hour_count.sv
design/ghbd_compare.sv
design/gregorian_hours_between_dates.sv
design/ghbd_checker.sv
verif/gregorian_hours_between_dates_checker.sv
verif/gregorian_hours_between_dates_tb.sv
